// ----- sv/crip_pkg.sv -----
// shared types, widths and constants of the catmull-rom interpolator
`timescale 1ns / 1ps

package crip_pkg;

  localparam int unsigned CRIP_CORDIC_STEPS = 20;
  localparam int unsigned REDUCE_STEPS      = 13;

  localparam int unsigned MAG_W = 56;
  localparam int unsigned R_W   = 45;
  localparam int unsigned Z_W   = 34;
  localparam int unsigned X_W   = 34;
  localparam int unsigned H_W   = 35;
  localparam int unsigned V_W   = 36;
  localparam int unsigned W_W   = 30;

  localparam logic [16:0]            T_ONE       = 17'd65536;
  localparam logic [42:0]            TWO_PI_Q40  = 43'h6487ED5110B;
  localparam logic signed [R_W-1:0]  TWO_PI_R    = 45'sh6487ED5110B;
  localparam logic signed [R_W-1:0]  PI_R        = 45'sh3243F6A8886;
  localparam logic signed [Z_W-1:0]  PI_Q30      = 34'shC90FDAA2;
  localparam logic signed [Z_W-1:0]  HALF_PI_Q30 = 34'sh6487ED51;
  localparam logic signed [X_W-1:0]  GAIN_Q30    = 34'sh26DD3B6A;
  localparam logic signed [20:0]     PI_Q16      = 21'sd205887;
  localparam logic signed [W_W-1:0]  ONE_Q28     = 30'sd268435456;

  localparam logic [29:0] ATAN_Q30 [32] = '{
    30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76, 30'h01FFD55B,
    30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD, 30'h000FFFFF, 30'h0007FFFF,
    30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF, 30'h00007FFF, 30'h00003FFF, 30'h00001FFF,
    30'h00000FFF, 30'h000007FF, 30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F,
    30'h0000003F, 30'h0000001F, 30'h0000000F, 30'h00000008, 30'h00000004, 30'h00000002,
    30'h00000001, 30'h00000000
  };

  typedef struct packed {
    logic               req_type;
    logic signed [31:0] sample_before;
    logic signed [31:0] sample_start;
    logic signed [31:0] sample_end;
    logic signed [31:0] sample_after;
    logic [16:0]        position;
  } in_t;

  typedef struct packed {
    logic signed [31:0] interpolated;
    logic               saturated;
  } out_t;

  typedef struct packed {
    logic signed [W_W-1:0] h00;
    logic signed [W_W-1:0] h01;
    logic signed [W_W-1:0] h10;
    logic signed [W_W-1:0] h11;
  } wgt_t;

  typedef struct packed {
    logic             req_type;
    logic [3:0][31:0] smp;
    wgt_t             wgt;
  } side_t;

  typedef struct packed {
    logic                  flip;
    logic signed [X_W-1:0] x;
    logic signed [X_W-1:0] y;
    logic signed [Z_W-1:0] z;
  } lane_t;

  typedef struct packed {
    logic                  req_type;
    logic                  zero;
    logic [31:0]           plain;
    logic                  sat;
    logic signed [V_W-1:0] x;
    logic signed [V_W-1:0] y;
    logic signed [Z_W-1:0] z;
  } vec_t;

endpackage

// ----- sv/crip_if.sv -----
// valid/ready channel interfaces for request and result transactions
`timescale 1ns / 1ps

interface crip_in_if import crip_pkg::*; ();
  logic valid;
  logic ready;
  in_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface crip_out_if import crip_pkg::*; ();
  logic valid;
  logic ready;
  out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- sv/catmull_rom_interp_with_angle_mode.sv -----
// catmull-rom interpolator top level with plain and angle mode
// the path runs through the front, modulo reduction, fold, rotation cordic, hermite, vectoring cordic and output stages
// throughput: one transaction per cycle while the output is not stalled, set by the fully pipelined cell chains
// the whole pipeline advances together and holds only while a result waits at the output
// reset clears the valid pipeline, payload registers are not reset
`timescale 1ns / 1ps

module catmull_rom_interp_with_angle_mode import crip_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = CRIP_CORDIC_STEPS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  crip_in_if.sink     in_i,
  crip_out_if.source  out_o
);

  localparam int unsigned DEPTH = 2 * CORDIC_STEPS + 24;

  logic             en;
  logic [DEPTH-1:0] vld_d, vld_q;

  logic [3:0][MAG_W-1:0] mod_mag [REDUCE_STEPS+1];
  logic [3:0]            mod_neg [REDUCE_STEPS+1];
  side_t                 mod_side [REDUCE_STEPS+1];
  lane_t [3:0]           rot_lane [CORDIC_STEPS+1];
  side_t                 rot_side [CORDIC_STEPS+1];
  vec_t                  vec_c [CORDIC_STEPS+1];

  assign en          = !vld_q[DEPTH-1] || out_o.ready;
  assign in_i.ready  = en;
  assign vld_d       = {vld_q[DEPTH-2:0], in_i.valid};
  assign out_o.valid = vld_q[DEPTH-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  crip_front u_front (
    .clk_i  (clk_i),
    .en_i   (en),
    .din_i  (in_i.data),
    .side_o (mod_side[0]),
    .mag_o  (mod_mag[0]),
    .neg_o  (mod_neg[0])
  );

  for (genvar j = 0; j < REDUCE_STEPS; j++) begin : g_mod
    crip_mod_cell #(.SHIFT(REDUCE_STEPS - 1 - j)) u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .mag_i  (mod_mag[j]),
      .neg_i  (mod_neg[j]),
      .side_i (mod_side[j]),
      .mag_o  (mod_mag[j+1]),
      .neg_o  (mod_neg[j+1]),
      .side_o (mod_side[j+1])
    );
  end

  crip_fold u_fold (
    .clk_i  (clk_i),
    .en_i   (en),
    .mag_i  (mod_mag[REDUCE_STEPS]),
    .neg_i  (mod_neg[REDUCE_STEPS]),
    .side_i (mod_side[REDUCE_STEPS]),
    .lane_o (rot_lane[0]),
    .side_o (rot_side[0])
  );

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    crip_rot_cell #(.IDX(i)) u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .lane_i (rot_lane[i]),
      .side_i (rot_side[i]),
      .lane_o (rot_lane[i+1]),
      .side_o (rot_side[i+1])
    );
  end

  crip_herm u_herm (
    .clk_i  (clk_i),
    .en_i   (en),
    .lane_i (rot_lane[CORDIC_STEPS]),
    .side_i (rot_side[CORDIC_STEPS]),
    .vec_o  (vec_c[0])
  );

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec
    crip_vec_cell #(.IDX(i)) u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .vec_i (vec_c[i]),
      .vec_o (vec_c[i+1])
    );
  end

  // final rounding of the angle to q16.16 and result select
  vec_t                  vl;
  logic signed [Z_W-1:0] zabs;
  logic [Z_W-1:0]        zsum;
  logic signed [20:0]    ang, angc;
  out_t                  res_d, res_q;
  logic                  req_q;

  assign vl   = vec_c[CORDIC_STEPS];
  assign zabs = vl.z[Z_W-1] ? -vl.z : vl.z;
  assign zsum = zabs + Z_W'(8192);
  assign ang  = vl.z[Z_W-1] ? -$signed({1'b0, zsum[33:14]}) : $signed({1'b0, zsum[33:14]});

  always_comb begin
    if (ang > PI_Q16) angc = PI_Q16;
    else if (ang < -PI_Q16) angc = -PI_Q16;
    else angc = ang;
    if (vl.req_type) begin
      res_d.interpolated = vl.zero ? 32'sd0 : 32'(angc);
      res_d.saturated    = 1'b0;
    end else begin
      res_d.interpolated = vl.plain;
      res_d.saturated    = vl.sat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
      req_q <= vl.req_type;
    end
  end

  assign out_o.data = res_q;

  a_sat_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.data.saturated) |->
      (out_o.data.interpolated == 32'sh7FFFFFFF ||
       out_o.data.interpolated == 32'sh80000000))
    else $error("saturated result is not a clamp value");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && req_q) |->
      (!out_o.data.saturated && out_o.data.interpolated <= 32'sd205887 &&
       out_o.data.interpolated >= -32'sd205887))
    else $error("angle result out of range");

  a_valid_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en |=> (vld_q[0] == $past(in_i.valid)))
    else $error("valid pipeline lost an input transaction");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("valid pipeline moved while stalled");

endmodule

// ----- sv/crip_front.sv -----
// input register, angle magnitudes and hermite basis weights (three stages)
`timescale 1ns / 1ps

module crip_front import crip_pkg::*; (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  in_t                    din_i,
  output side_t                  side_o,
  output logic [3:0][MAG_W-1:0]  mag_o,
  output logic [3:0]             neg_o
);

  logic [3:0][31:0]    smp;
  logic [16:0]         tc;
  logic [32:0]         t2_d;
  logic [3:0][MAG_W-1:0] mag_d;
  logic [3:0]          neg_d;

  logic                req0_q, req1_q, req2_q;
  logic [3:0][31:0]    smp0_q, smp1_q, smp2_q;
  logic [3:0][MAG_W-1:0] mag0_q, mag1_q, mag2_q;
  logic [3:0]          neg0_q, neg1_q, neg2_q;
  logic [16:0]         t0_q, t1_q;
  logic [32:0]         t20_q, t21_q;
  logic [49:0]         t3_d, t3_q;
  wgt_t                wgt_d, wgt_q;

  logic [51:0] t2x, t3x, t1x, w01, w10, w11, r01, r10, r11;

  assign smp = {din_i.sample_after, din_i.sample_end, din_i.sample_start,
                din_i.sample_before};
  assign tc = (din_i.position > T_ONE) ? T_ONE : din_i.position;
  assign t2_d = {16'b0, tc} * {16'b0, tc};

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      neg_d[k] = smp[k][31];
      mag_d[k] = {(neg_d[k] ? 32'(-smp[k]) : smp[k]), 24'b0};
    end
  end

  assign t3_d = 50'(t20_q) * 50'(t0_q);

  assign t2x = {3'b0, t21_q, 16'b0};
  assign t3x = {2'b0, t3_q};
  assign t1x = {3'b0, t1_q, 32'b0};
  assign w01 = (t2x << 1) + t2x - (t3x << 1);
  assign w10 = t3x - (t2x << 1) + t1x;
  assign w11 = t2x - t3x;
  assign r01 = w01 + 52'd524288;
  assign r10 = w10 + 52'd524288;
  assign r11 = w11 + 52'd524288;

  always_comb begin
    wgt_d.h01 = $signed({1'b0, r01[48:20]});
    wgt_d.h00 = ONE_Q28 - $signed({1'b0, r01[48:20]});
    wgt_d.h10 = $signed({1'b0, r10[48:20]});
    wgt_d.h11 = -$signed({1'b0, r11[48:20]});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      req0_q <= din_i.req_type;
      smp0_q <= smp;
      mag0_q <= mag_d;
      neg0_q <= neg_d;
      t0_q   <= tc;
      t20_q  <= t2_d;
      req1_q <= req0_q;
      smp1_q <= smp0_q;
      mag1_q <= mag0_q;
      neg1_q <= neg0_q;
      t1_q   <= t0_q;
      t21_q  <= t20_q;
      t3_q   <= t3_d;
      req2_q <= req1_q;
      smp2_q <= smp1_q;
      mag2_q <= mag1_q;
      neg2_q <= neg1_q;
      wgt_q  <= wgt_d;
    end
  end

  assign side_o = '{req_type: req2_q, smp: smp2_q, wgt: wgt_q};
  assign mag_o  = mag2_q;
  assign neg_o  = neg2_q;

endmodule

// ----- sv/crip_mod_cell.sv -----
// one restoring step of the modulo two pi reduction for four angles
`timescale 1ns / 1ps

module crip_mod_cell import crip_pkg::*; #(
  parameter int unsigned SHIFT = 0
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [3:0][MAG_W-1:0]  mag_i,
  input  logic [3:0]             neg_i,
  input  side_t                  side_i,
  output logic [3:0][MAG_W-1:0]  mag_o,
  output logic [3:0]             neg_o,
  output side_t                  side_o
);

  localparam logic [MAG_W-1:0] STEP = MAG_W'(TWO_PI_Q40) << SHIFT;

  logic [3:0][MAG_W-1:0] mag_d, mag_q;
  logic [3:0]            neg_q;
  side_t                 side_q;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      mag_d[k] = (mag_i[k] >= STEP) ? mag_i[k] - STEP : mag_i[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q  <= mag_d;
      neg_q  <= neg_i;
      side_q <= side_i;
    end
  end

  assign mag_o  = mag_q;
  assign neg_o  = neg_q;
  assign side_o = side_q;

endmodule

// ----- sv/crip_fold.sv -----
// wrap to minus pi..pi, round to q30 and fold into the cordic range
`timescale 1ns / 1ps

module crip_fold import crip_pkg::*; (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [3:0][MAG_W-1:0]  mag_i,
  input  logic [3:0]             neg_i,
  input  side_t                  side_i,
  output lane_t [3:0]            lane_o,
  output side_t                  side_o
);

  logic signed [R_W-1:0] r_d [4];
  logic signed [R_W-1:0] r_q [4];
  side_t                 side1_q, side2_q;
  lane_t [3:0]           lane_d, lane_q;

  logic signed [R_W-1:0] rm, rabs;
  logic [R_W-1:0]        rsum;
  logic signed [Z_W-1:0] zq, zr;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      rm = $signed({2'b0, mag_i[k][42:0]});
      if (neg_i[k]) rm = -rm;
      if (rm >= PI_R) r_d[k] = rm - TWO_PI_R;
      else if (rm < -PI_R) r_d[k] = rm + TWO_PI_R;
      else r_d[k] = rm;
    end
  end

  always_comb begin
    rabs = '0;
    rsum = '0;
    zq   = '0;
    zr   = '0;
    for (int k = 0; k < 4; k++) begin
      rabs = r_q[k][R_W-1] ? -r_q[k] : r_q[k];
      rsum = rabs + R_W'(512);
      zq   = $signed({1'b0, rsum[42:10]});
      zr   = r_q[k][R_W-1] ? -zq : zq;
      lane_d[k].x = GAIN_Q30;
      lane_d[k].y = '0;
      if (zr > HALF_PI_Q30) begin
        lane_d[k].z    = zr - PI_Q30;
        lane_d[k].flip = 1'b1;
      end else if (zr < -HALF_PI_Q30) begin
        lane_d[k].z    = zr + PI_Q30;
        lane_d[k].flip = 1'b1;
      end else begin
        lane_d[k].z    = zr;
        lane_d[k].flip = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q     <= r_d;
      side1_q <= side_i;
      lane_q  <= lane_d;
      side2_q <= side1_q;
    end
  end

  assign lane_o = lane_q;
  assign side_o = side2_q;

endmodule

// ----- sv/crip_rot_cell.sv -----
// one rotation cordic iteration for four angles
`timescale 1ns / 1ps

module crip_rot_cell import crip_pkg::*; #(
  parameter int unsigned IDX = 0
) (
  input  logic        clk_i,
  input  logic        en_i,
  input  lane_t [3:0] lane_i,
  input  side_t       side_i,
  output lane_t [3:0] lane_o,
  output side_t       side_o
);

  localparam logic signed [Z_W-1:0] ANG = $signed({4'b0, ATAN_Q30[IDX % 32]});

  lane_t [3:0] lane_d, lane_q;
  side_t       side_q;
  logic signed [X_W-1:0] dx, dy;

  always_comb begin
    dx = '0;
    dy = '0;
    for (int k = 0; k < 4; k++) begin
      dx = $signed(lane_i[k].y) >>> IDX;
      dy = $signed(lane_i[k].x) >>> IDX;
      lane_d[k].flip = lane_i[k].flip;
      if (!lane_i[k].z[Z_W-1]) begin
        lane_d[k].x = lane_i[k].x - dx;
        lane_d[k].y = lane_i[k].y + dy;
        lane_d[k].z = lane_i[k].z - ANG;
      end else begin
        lane_d[k].x = lane_i[k].x + dx;
        lane_d[k].y = lane_i[k].y - dy;
        lane_d[k].z = lane_i[k].z + ANG;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
      side_q <= side_i;
    end
  end

  assign lane_o = lane_q;
  assign side_o = side_q;

endmodule

// ----- sv/crip_herm.sv -----
// hermite weighted sums for sine and cosine lanes, plain clamp, atan2 setup
`timescale 1ns / 1ps

module crip_herm import crip_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  lane_t [3:0] lane_i,
  input  side_t       side_i,
  output vec_t        vec_o
);

  // lane 0 carries sine (or the plain samples), lane 1 cosine
  logic signed [X_W-1:0] hp_d [2][4];
  logic signed [X_W-1:0] hp_q [2][4];
  logic                  req0_q, req1_q, req2_q, req3_q;
  wgt_t                  wgt0_q, wgt1_q;

  logic signed [H_W-1:0] d20_q [2];
  logic signed [H_W-1:0] d31_q [2];
  logic signed [H_W-1:0] p1_q [2];
  logic signed [H_W-1:0] p2_q [2];
  logic signed [63:0]    prod_d [2][4];
  logic signed [63:0]    prod_q [2][4];
  logic signed [63:0]    acc [2];
  logic signed [H_W-1:0] res_d [2];
  logic signed [H_W-1:0] res_q [2];
  vec_t                  vec_d, vec_q;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      hp_d[0][k] = side_i.req_type ?
                   (lane_i[k].flip ? -lane_i[k].y : lane_i[k].y) :
                   X_W'($signed(side_i.smp[k]));
      hp_d[1][k] = lane_i[k].flip ? -lane_i[k].x : lane_i[k].x;
    end
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      prod_d[l][0] = 64'(p1_q[l]) * 64'(wgt1_q.h00);
      prod_d[l][1] = 64'(p2_q[l]) * 64'(wgt1_q.h01);
      prod_d[l][2] = 64'(d20_q[l]) * 64'(wgt1_q.h10);
      prod_d[l][3] = 64'(d31_q[l]) * 64'(wgt1_q.h11);
      acc[l] = ((prod_q[l][0] + prod_q[l][1]) <<< 1) + prod_q[l][2] + prod_q[l][3]
               + 64'sd268435456;
      res_d[l] = H_W'(acc[l] >>> 29);
    end
  end

  always_comb begin
    vec_d.req_type = req3_q;
    vec_d.zero     = (res_q[0] == '0) && (res_q[1] == '0);
    if (res_q[0] > 35'sd2147483647) begin
      vec_d.plain = 32'h7FFFFFFF;
      vec_d.sat   = 1'b1;
    end else if (res_q[0] < -35'sd2147483648) begin
      vec_d.plain = 32'h80000000;
      vec_d.sat   = 1'b1;
    end else begin
      vec_d.plain = res_q[0][31:0];
      vec_d.sat   = 1'b0;
    end
    if (res_q[1][H_W-1]) begin
      vec_d.x = -V_W'(res_q[1]);
      vec_d.y = -V_W'(res_q[0]);
      vec_d.z = res_q[0][H_W-1] ? -PI_Q30 : PI_Q30;
    end else begin
      vec_d.x = V_W'(res_q[1]);
      vec_d.y = V_W'(res_q[0]);
      vec_d.z = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hp_q   <= hp_d;
      req0_q <= side_i.req_type;
      wgt0_q <= side_i.wgt;
      for (int l = 0; l < 2; l++) begin
        d20_q[l] <= H_W'(hp_q[l][2]) - H_W'(hp_q[l][0]);
        d31_q[l] <= H_W'(hp_q[l][3]) - H_W'(hp_q[l][1]);
        p1_q[l]  <= H_W'(hp_q[l][1]);
        p2_q[l]  <= H_W'(hp_q[l][2]);
      end
      req1_q <= req0_q;
      wgt1_q <= wgt0_q;
      prod_q <= prod_d;
      req2_q <= req1_q;
      res_q  <= res_d;
      req3_q <= req2_q;
      vec_q  <= vec_d;
    end
  end

  assign vec_o = vec_q;

endmodule

// ----- sv/crip_vec_cell.sv -----
// one vectoring cordic iteration of the atan2 chain
`timescale 1ns / 1ps

module crip_vec_cell import crip_pkg::*; #(
  parameter int unsigned IDX = 0
) (
  input  logic clk_i,
  input  logic en_i,
  input  vec_t vec_i,
  output vec_t vec_o
);

  localparam logic signed [Z_W-1:0] ANG = $signed({4'b0, ATAN_Q30[IDX % 32]});

  vec_t vec_d, vec_q;
  logic signed [V_W-1:0] dx, dy;

  always_comb begin
    vec_d = vec_i;
    dx = $signed(vec_i.y) >>> IDX;
    dy = $signed(vec_i.x) >>> IDX;
    if (!vec_i.y[V_W-1]) begin
      vec_d.x = vec_i.x + dx;
      vec_d.y = vec_i.y - dy;
      vec_d.z = vec_i.z + ANG;
    end else begin
      vec_d.x = vec_i.x - dx;
      vec_d.y = vec_i.y + dy;
      vec_d.z = vec_i.z - ANG;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) vec_q <= vec_d;
  end

  assign vec_o = vec_q;

endmodule
